// ===== rtl/tcpf_pkg.sv =====
// Package for the three-class priority FIFO: sizes, codes and threshold helpers.
`timescale 1ns / 1ps

package tcpf_pkg;

  localparam int CLASS_DEPTH = 16;
  localparam int NUM_CLASSES = 3;

  localparam int DATE_W  = 27;
  localparam int CODE_W  = 48;
  localparam int LIMIT_W = 14;
  localparam int CFG_W   = 27;
  localparam int CLS_W   = 2;
  localparam int STAT_W  = 2;
  localparam int WORD_W  = DATE_W + CODE_W;

  localparam int PTR_W  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_CLASSES * CLASS_DEPTH);
  localparam int SLOTS  = NUM_CLASSES * CLASS_DEPTH;

  // date difference plus sign and headroom for (limit + 1) * AGE_UNIT
  localparam int DIFF_W   = 29;
  localparam int AGE_UNIT = 10000;

  localparam logic [DATE_W-1:0]  REF_DATE_RST  = DATE_W'(20240705);
  localparam logic [LIMIT_W-1:0] OLD_LIM_RST   = LIMIT_W'(80);
  localparam logic [LIMIT_W-1:0] YOUNG_LIM_RST = LIMIT_W'(10);

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_REF_DATE    = 2'd0,
    CFG_OLD_LIMIT   = 2'd1,
    CFG_YOUNG_LIMIT = 2'd2
  } cfg_idx_t;

  // age > limit  <=>  diff >= (limit + 1) * AGE_UNIT
  function automatic logic signed [DIFF_W-1:0] old_thr(input logic [LIMIT_W-1:0] lim);
    logic [DIFF_W-1:0] t;
    t = DIFF_W'(lim) + DIFF_W'(1);
    return $signed(DIFF_W'(t * DIFF_W'(AGE_UNIT)));
  endfunction

  // age < limit  <=>  diff < limit * AGE_UNIT, or diff < -(AGE_UNIT - 1) when limit is zero
  function automatic logic signed [DIFF_W-1:0] young_thr(input logic [LIMIT_W-1:0] lim);
    logic [DIFF_W-1:0] t;
    if (lim == '0) begin
      t = DIFF_W'(0) - DIFF_W'(AGE_UNIT - 1);
    end else begin
      t = DIFF_W'(DIFF_W'(lim) * DIFF_W'(AGE_UNIT));
    end
    return $signed(t);
  endfunction

  function automatic logic [ADDR_W-1:0] class_base(input logic [CLS_W-1:0] cls);
    return ADDR_W'(ADDR_W'(cls) * ADDR_W'(CLASS_DEPTH));
  endfunction

endpackage

// ===== rtl/three_class_priority_fifo.sv =====
// Three-class priority FIFO: classifies pushed words by age, pops the lowest-numbered non-empty class first.
`timescale 1ns / 1ps

// A push passes through accept and decide states, and a pop also through a read state:
// each word is accepted, then classified and applied to the class pointers, and a pop
// then waits for the registered read of the shared entry memory (3 x CLASS_DEPTH words
// of date and code). One word is in flight at a time; a finished result sits in the
// output register and the next word is accepted meanwhile. Ages are compared against
// thresholds that are scaled when a limit register is written, so no division is done
// per word. Configuration writes take effect at once and are meant for idle periods only.
module three_class_priority_fifo
  import tcpf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic [DATE_W-1:0]   in_birth_date,
  input  logic [CODE_W-1:0]   in_entry_code,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAT_W-1:0]   out_status,
  output logic [CLS_W-1:0]    out_item_class,
  output logic [DATE_W-1:0]   out_popped_date,
  output logic [CODE_W-1:0]   out_popped_code
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_READ
  } state_t;

  state_t                   state_r;
  cmd_t                     cmd_r;
  logic [DATE_W-1:0]        date_r;
  logic [CODE_W-1:0]        code_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [CLS_W-1:0]         pop_cls_r;

  logic [DATE_W-1:0]        ref_date_r;
  logic signed [DIFF_W-1:0] old_thr_r;
  logic signed [DIFF_W-1:0] young_thr_r;

  logic [PTR_W-1:0]         rd_ptr_r [NUM_CLASSES];
  logic [PTR_W-1:0]         wr_ptr_r [NUM_CLASSES];
  logic [CNT_W-1:0]         fill_r   [NUM_CLASSES];

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [CLS_W-1:0]         out_class_r;
  logic [DATE_W-1:0]        out_date_r;
  logic [CODE_W-1:0]        out_code_r;

  logic [WORD_W-1:0]        mem [SLOTS];
  logic [WORD_W-1:0]        mem_rdata_r;
  logic                     mem_we;
  logic                     mem_re;
  logic [ADDR_W-1:0]        mem_addr;

  logic [CLS_W-1:0]         push_cls;
  logic [CLS_W-1:0]         pop_cls;
  logic [CLS_W-1:0]         sel_cls;
  logic                     pop_any;
  logic                     push_full;
  logic                     out_free;
  logic                     out_load;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    if (diff_r >= old_thr_r) begin
      push_cls = CLS_W'(0);
    end else if (diff_r < young_thr_r) begin
      push_cls = CLS_W'(1);
    end else begin
      push_cls = CLS_W'(2);
    end
  end

  always_comb begin
    pop_any = 1'b1;
    if (fill_r[0] != '0) begin
      pop_cls = CLS_W'(0);
    end else if (fill_r[1] != '0) begin
      pop_cls = CLS_W'(1);
    end else if (fill_r[2] != '0) begin
      pop_cls = CLS_W'(2);
    end else begin
      pop_cls = CLS_W'(0);
      pop_any = 1'b0;
    end
  end

  assign sel_cls   = (cmd_r == CMD_PUSH) ? push_cls : pop_cls;
  assign push_full = (fill_r[push_cls] == CNT_W'(CLASS_DEPTH));
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = out_free && (((state_r == S_DECIDE) && !((cmd_r == CMD_POP) && pop_any)) ||
                                  (state_r == S_READ));
  assign mem_addr  = class_base(sel_cls) + ADDR_W'((cmd_r == CMD_PUSH) ? wr_ptr_r[sel_cls]
                                                                      : rd_ptr_r[sel_cls]);
  assign mem_we    = (state_r == S_DECIDE) && (cmd_r == CMD_PUSH) && out_free && !push_full;
  assign mem_re    = (state_r == S_DECIDE) && (cmd_r == CMD_POP) && pop_any;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {date_r, code_r};
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ref_date_r  <= REF_DATE_RST;
      old_thr_r   <= old_thr(OLD_LIM_RST);
      young_thr_r <= young_thr(YOUNG_LIM_RST);
      for (int k = 0; k < NUM_CLASSES; k++) begin
        rd_ptr_r[k] <= '0;
        wr_ptr_r[k] <= '0;
        fill_r[k]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_REF_DATE:    ref_date_r  <= cfg_data[DATE_W-1:0];
          CFG_OLD_LIMIT:   old_thr_r   <= old_thr(cfg_data[LIMIT_W-1:0]);
          CFG_YOUNG_LIMIT: young_thr_r <= young_thr(cfg_data[LIMIT_W-1:0]);
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd_t'(in_cmd);
            date_r  <= in_birth_date;
            code_r  <= in_entry_code;
            diff_r  <= $signed({2'b00, ref_date_r}) - $signed({2'b00, in_birth_date});
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (cmd_r == CMD_PUSH) begin
            if (out_free) begin
              out_class_r <= push_cls;
              out_date_r  <= '0;
              out_code_r  <= '0;
              if (push_full) begin
                out_status_r <= ST_FULL;
              end else begin
                out_status_r       <= ST_DONE;
                wr_ptr_r[push_cls] <= ptr_adv(wr_ptr_r[push_cls]);
                fill_r[push_cls]   <= fill_r[push_cls] + CNT_W'(1);
              end
              state_r <= S_IDLE;
            end
          end else if (!pop_any) begin
            if (out_free) begin
              out_status_r <= ST_EMPTY;
              out_class_r  <= '0;
              out_date_r   <= '0;
              out_code_r   <= '0;
              state_r      <= S_IDLE;
            end
          end else begin
            rd_ptr_r[pop_cls] <= ptr_adv(rd_ptr_r[pop_cls]);
            fill_r[pop_cls]   <= fill_r[pop_cls] - CNT_W'(1);
            pop_cls_r         <= pop_cls;
            state_r           <= S_READ;
          end
        end
        S_READ: begin
          if (out_free) begin
            out_status_r <= ST_DONE;
            out_class_r  <= pop_cls_r;
            out_date_r   <= mem_rdata_r[WORD_W-1:CODE_W];
            out_code_r   <= mem_rdata_r[CODE_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_item_class  = out_class_r;
  assign out_popped_date = out_date_r;
  assign out_popped_code = out_code_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= CNT_W'(CLASS_DEPTH)) && (fill_r[1] <= CNT_W'(CLASS_DEPTH)) &&
    (fill_r[2] <= CNT_W'(CLASS_DEPTH)))
    else $error("class fill count above depth");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (fill_r[push_cls] < CNT_W'(CLASS_DEPTH)))
    else $error("entry written into a full class");

  a_read_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && cmd_r == CMD_POP && pop_any) |=> (state_r == S_READ))
    else $error("pop read not followed by read state");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EMPTY) |->
      (out_class_r == '0 && out_date_r == '0 && out_code_r == '0))
    else $error("empty pop result carries data");

endmodule
